### src/ecdsa_der_to_raw_signature_macros.svh
`ifndef ECDSA_DER_TO_RAW_SIGNATURE_MACROS_SVH
`define ECDSA_DER_TO_RAW_SIGNATURE_MACROS_SVH

// same-cycle implication
`define EDR_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define EDR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/edr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package edr_pkg;

   localparam int COORD_BYTES   = 32;
   localparam int MAX_INT_BYTES = 33;
   localparam int CNT_W         = $clog2(MAX_INT_BYTES + 1);
   localparam int BYTE_W        = 8;
   localparam int STAT_W        = 3;
   localparam int QDEPTH        = 4;
   localparam int QPTR_W        = $clog2(QDEPTH);

   localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
   localparam logic [STAT_W-1:0] ST_SEQ_TAG  = 3'd1;
   localparam logic [STAT_W-1:0] ST_BAD_LEN  = 3'd2;
   localparam logic [STAT_W-1:0] ST_MISMATCH = 3'd3;
   localparam logic [STAT_W-1:0] ST_INT_TAG  = 3'd4;
   localparam logic [STAT_W-1:0] ST_TOO_LONG = 3'd5;
   localparam logic [STAT_W-1:0] ST_TRUNC    = 3'd6;

   typedef struct packed {
      logic [CNT_W-1:0]  pad;
      logic              data_vld;
      logic [BYTE_W-1:0] data;
      logic              stat_vld;
      logic [STAT_W-1:0] stat;
   } cmd_type;

endpackage
`default_nettype wire

### src/edr_req_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface edr_req_if import edr_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] der_byte;
   logic              final_byte;

   modport source (output valid, output der_byte, output final_byte, input ready);
   modport sink (input valid, input der_byte, input final_byte, output ready);
endinterface
`default_nettype wire

### src/edr_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface edr_rsp_if import edr_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] out_byte;
   logic              is_status;
   logic [STAT_W-1:0] status;
   logic              last;

   modport source (output valid, output out_byte, output is_status, output status,
                   output last, input ready);
   modport sink (input valid, input out_byte, input is_status, input status,
                 input last, output ready);
endinterface
`default_nettype wire

### src/ecdsa_der_to_raw_signature.sv
`timescale 1ns / 1ps
`default_nettype none
// channel  dir  handshake          words
// req_ch   in   valid/ready        der_byte, final_byte
// rsp_ch   out  valid/ready        out_byte, is_status, status, last
//
// One input word is taken per cycle while the four-entry command queue has room.
// The output stage sends one word per cycle while rsp_ch is ready; an integer shorter
// than 32 bytes costs up to 32 zero words from one queue entry at its length word, so
// input waits once the queue fills. Words are queued, then registered at the output.
// Reset is synchronous and returns the parser to the sequence tag.
// Either side may stall without loss; the queue absorbs the difference.
`include "ecdsa_der_to_raw_signature_macros.svh"
module ecdsa_der_to_raw_signature import edr_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   edr_req_if.sink   req_ch,
   edr_rsp_if.source rsp_ch
);

   logic    q_push;
   logic    q_pop;
   logic    q_full;
   logic    q_empty;
   cmd_type q_wr;
   cmd_type q_rd;

   edr_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req    (req_ch),
      .q_full (q_full),
      .q_push (q_push),
      .q_cmd  (q_wr)
   );

   edr_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (q_push),
      .wr_cmd (q_wr),
      .full   (q_full),
      .pop    (q_pop),
      .rd_cmd (q_rd),
      .empty  (q_empty)
   );

   edr_back u_back (
      .clock (clock),
      .reset (reset),
      .cmd   (q_rd),
      .empty (q_empty),
      .pop   (q_pop),
      .rsp   (rsp_ch)
   );

   `EDR_ASSERT_NOW(a_no_push_full, clock, reset, q_push, !q_full, "push into full queue")
   `EDR_ASSERT_NOW(a_no_pop_empty, clock, reset, q_pop, !q_empty, "pop from empty queue")
   `EDR_ASSERT_NOW(a_status_last, clock, reset, rsp_ch.valid && rsp_ch.is_status, rsp_ch.last && rsp_ch.out_byte == 8'h00, "status word malformed")
   `EDR_ASSERT_NOW(a_data_clean, clock, reset, rsp_ch.valid && !rsp_ch.is_status, !rsp_ch.last && rsp_ch.status == ST_OK, "data word malformed")

endmodule
`default_nettype wire

### src/edr_front.sv
`timescale 1ns / 1ps
`default_nettype none
module edr_front import edr_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   edr_req_if.sink     req,
   input  wire logic   q_full,
   output logic        q_push,
   output cmd_type     q_cmd
);

   localparam logic [3:0] PH_SEQ_TAG  = 4'd0;
   localparam logic [3:0] PH_SEQ_LEN  = 4'd1;
   localparam logic [3:0] PH_SEQ_LEXT = 4'd2;
   localparam logic [3:0] PH_INT_TAG  = 4'd3;
   localparam logic [3:0] PH_INT_LEN  = 4'd4;
   localparam logic [3:0] PH_INT_LEXT = 4'd5;
   localparam logic [3:0] PH_INT_BODY = 4'd6;
   localparam logic [3:0] PH_TRAIL    = 4'd7;
   localparam logic [3:0] PH_ERR      = 4'd8;

   localparam logic [7:0] TAG_SEQ  = 8'h30;
   localparam logic [7:0] TAG_INT  = 8'h02;
   localparam logic [7:0] LEN_LONG = 8'h80;
   localparam logic [7:0] LEN_81   = 8'h81;
   localparam logic [7:0] LEN_82   = 8'h82;

   logic [3:0]       phase_ff, phase_in;
   logic [15:0]      decl_ff, decl_in;
   logic [1:0]       lleft_ff, lleft_in;
   logic [15:0]      count_ff, count_in;
   logic [CNT_W-1:0] ileft_ff, ileft_in;
   logic [CNT_W-1:0] skip_ff, skip_in;
   logic             second_ff, second_in;

   logic              accept;
   logic              fin;
   logic [7:0]        b;
   logic              known;
   logic              known_n;
   logic [16:0]       cnt_inc;
   logic [STAT_W-1:0] err;
   logic              start_go;
   logic [CNT_W-1:0]  start_n;
   logic [3:0]        done_phase;
   cmd_type           cmd;

   assign accept    = req.valid && req.ready;
   assign req.ready = !q_full;
   assign fin       = req.final_byte;
   assign b         = req.der_byte;
   assign known     = (phase_ff >= PH_INT_TAG) && (phase_ff <= PH_TRAIL);
   assign cnt_inc   = {1'b0, count_ff} + 17'd1;
   assign done_phase = second_ff ? PH_TRAIL : PH_INT_TAG;

   always_comb begin
      phase_in  = phase_ff;
      decl_in   = decl_ff;
      lleft_in  = lleft_ff;
      count_in  = count_ff;
      ileft_in  = ileft_ff;
      skip_in   = skip_ff;
      second_in = second_ff;
      err       = ST_OK;
      start_go  = 1'b0;
      start_n   = b[CNT_W-1:0];
      cmd       = '0;

      if (known) begin
         count_in = cnt_inc[15:0];
         if ((cnt_inc > {1'b0, decl_ff}) || (fin && (cnt_inc != {1'b0, decl_ff}))) begin
            err = ST_MISMATCH;
         end
      end

      if (err == ST_OK) begin
         case (phase_ff)
            PH_SEQ_TAG: begin
               if (b != TAG_SEQ) err = ST_SEQ_TAG;
               else phase_in = PH_SEQ_LEN;
            end
            PH_SEQ_LEN: begin
               if (b < LEN_LONG) begin
                  decl_in  = {8'h00, b};
                  phase_in = PH_INT_TAG;
               end else if (b == LEN_81 || b == LEN_82) begin
                  decl_in  = '0;
                  lleft_in = b[1:0];
                  phase_in = PH_SEQ_LEXT;
               end else begin
                  err = ST_BAD_LEN;
               end
            end
            PH_SEQ_LEXT: begin
               decl_in  = {decl_ff[7:0], b};
               lleft_in = lleft_ff - 2'd1;
               if (lleft_ff == 2'd1) phase_in = PH_INT_TAG;
            end
            PH_INT_TAG: begin
               if (b != TAG_INT) err = ST_INT_TAG;
               else phase_in = PH_INT_LEN;
            end
            PH_INT_LEN: begin
               if (b < LEN_LONG) begin
                  if (b > 8'(MAX_INT_BYTES)) err = ST_TOO_LONG;
                  else start_go = 1'b1;
               end else if (b == LEN_81 || b == LEN_82) begin
                  lleft_in = b[1:0];
                  phase_in = PH_INT_LEXT;
               end else begin
                  err = ST_BAD_LEN;
               end
            end
            PH_INT_LEXT: begin
               if (lleft_ff > 2'd1) begin
                  if (b != 8'h00) err = ST_TOO_LONG;
                  else lleft_in = lleft_ff - 2'd1;
               end else begin
                  lleft_in = '0;
                  if (b > 8'(MAX_INT_BYTES)) err = ST_TOO_LONG;
                  else start_go = 1'b1;
               end
            end
            PH_INT_BODY: begin
               if (skip_ff != '0) begin
                  skip_in = skip_ff - 1'b1;
               end else begin
                  cmd.data_vld = 1'b1;
                  cmd.data     = b;
               end
               ileft_in = ileft_ff - 1'b1;
               if (ileft_ff == CNT_W'(1)) begin
                  second_in = 1'b1;
                  phase_in  = done_phase;
               end
            end
            default: begin
            end
         endcase
      end

      if (start_go) begin
         if (start_n < CNT_W'(COORD_BYTES)) begin
            cmd.pad = CNT_W'(COORD_BYTES) - start_n;
            skip_in = '0;
         end else begin
            skip_in = start_n - CNT_W'(COORD_BYTES);
         end
         ileft_in = start_n;
         if (start_n == '0) begin
            second_in = 1'b1;
            phase_in  = done_phase;
         end else begin
            phase_in = PH_INT_BODY;
         end
      end

      known_n = (phase_in >= PH_INT_TAG) && (phase_in <= PH_TRAIL);
      if (err == ST_OK && fin) begin
         if (known_n && (count_in != decl_in)) err = ST_MISMATCH;
         else if (phase_in != PH_TRAIL) err = ST_TRUNC;
      end

      if (err != ST_OK || fin) begin
         cmd.stat_vld = 1'b1;
         cmd.stat     = err;
         phase_in     = PH_ERR;
      end

      if (fin || phase_ff == PH_ERR) begin
         if (fin) begin
            phase_in  = PH_SEQ_TAG;
            decl_in   = '0;
            lleft_in  = '0;
            count_in  = '0;
            ileft_in  = '0;
            skip_in   = '0;
            second_in = 1'b0;
         end else begin
            phase_in = PH_ERR;
         end
      end
   end

   assign q_cmd  = cmd;
   assign q_push = accept && (phase_ff != PH_ERR) &&
                   ((cmd.pad != '0) || cmd.data_vld || cmd.stat_vld);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_SEQ_TAG;
         decl_ff   <= '0;
         lleft_ff  <= '0;
         count_ff  <= '0;
         ileft_ff  <= '0;
         skip_ff   <= '0;
         second_ff <= 1'b0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         decl_ff   <= decl_in;
         lleft_ff  <= lleft_in;
         count_ff  <= count_in;
         ileft_ff  <= ileft_in;
         skip_ff   <= skip_in;
         second_ff <= second_in;
      end
   end

endmodule
`default_nettype wire

### src/edr_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module edr_queue import edr_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire cmd_type wr_cmd,
   output logic         full,
   input  wire logic    pop,
   output cmd_type      rd_cmd,
   output logic         empty
);

   cmd_type           mem_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ff, wr_in;
   logic [QPTR_W-1:0] rd_ff, rd_in;
   logic [QPTR_W:0]   cnt_ff, cnt_in;

   assign full   = (cnt_ff == (QPTR_W + 1)'(QDEPTH));
   assign empty  = (cnt_ff == '0);
   assign rd_cmd = mem_ff[rd_ff];

   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff;
      if (push && !pop) cnt_in = cnt_ff + 1'b1;
      else if (pop && !push) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= wr_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule
`default_nettype wire

### src/edr_back.sv
`timescale 1ns / 1ps
`default_nettype none
module edr_back import edr_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire cmd_type cmd,
   input  wire logic    empty,
   output logic         pop,
   edr_rsp_if.source    rsp
);

   logic [CNT_W-1:0]  pidx_ff, pidx_in;
   logic              ddone_ff, ddone_in;
   logic              vld_ff, vld_in;
   logic [BYTE_W-1:0] byte_ff;
   logic              isst_ff;
   logic [STAT_W-1:0] stat_ff;
   logic              last_ff;

   logic adv;
   logic fire;
   logic pad_sel;
   logic data_sel;
   logic stat_sel;
   logic pad_last;
   logic done;

   assign adv      = !vld_ff || rsp.ready;
   assign fire     = adv && !empty;
   assign pad_sel  = !ddone_ff && (pidx_ff < cmd.pad);
   assign data_sel = !pad_sel && !ddone_ff && cmd.data_vld;
   assign stat_sel = !pad_sel && !data_sel;
   assign pad_last = (CNT_W'(pidx_ff + 1'b1) == cmd.pad);

   always_comb begin
      if (pad_sel) done = pad_last && !cmd.data_vld && !cmd.stat_vld;
      else if (data_sel) done = !cmd.stat_vld;
      else done = 1'b1;
   end

   assign pop = fire && done;

   always_comb begin
      pidx_in  = pidx_ff;
      ddone_in = ddone_ff;
      vld_in   = vld_ff;
      if (fire) begin
         if (done) begin
            pidx_in  = '0;
            ddone_in = 1'b0;
         end else if (pad_sel) begin
            pidx_in = pidx_ff + 1'b1;
         end else if (data_sel) begin
            ddone_in = 1'b1;
         end
      end
      if (adv) vld_in = !empty;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pidx_ff  <= '0;
         ddone_ff <= 1'b0;
         vld_ff   <= 1'b0;
      end else begin
         pidx_ff  <= pidx_in;
         ddone_ff <= ddone_in;
         vld_ff   <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         byte_ff <= data_sel ? cmd.data : '0;
         isst_ff <= stat_sel;
         stat_ff <= stat_sel ? cmd.stat : ST_OK;
         last_ff <= stat_sel;
      end
   end

   assign rsp.valid     = vld_ff;
   assign rsp.out_byte  = byte_ff;
   assign rsp.is_status = isst_ff;
   assign rsp.status    = stat_ff;
   assign rsp.last      = last_ff;

endmodule
`default_nettype wire

### bench/tb_ecdsa_der_to_raw_signature.sv
`timescale 1ns / 1ps
module tb_ecdsa_der_to_raw_signature;
   import edr_pkg::*;

   localparam logic [7:0] TAG_SEQUENCE  = 8'h30;
   localparam logic [7:0] TAG_INTEGER   = 8'h02;
   localparam logic [7:0] LEN_LONG_FORM = 8'h80;
   localparam logic [7:0] LEN_LONG1     = 8'h81;
   localparam logic [7:0] LEN_LONG2     = 8'h82;
   localparam int PHASE_WORDS    = 50;
   localparam int LONG_HOLD      = 150;
   localparam int TAIL_CYCLES    = 8;
   localparam int WATCHDOG_LIMIT = 2000;

   typedef enum logic [3:0] {
      AT_SEQ_TAG, AT_SEQ_LEN, AT_SEQ_LEN_EXT, AT_INT_TAG, AT_INT_LEN,
      AT_INT_LEN_EXT, AT_INT_VALUE, AT_TAIL, AT_DISCARD
   } der_parse_type;

   typedef struct {
      logic [7:0]        value;
      logic              fin;
      logic              pinned;
      logic [STAT_W-1:0] pinned_status;
   } der_word_type;

   typedef struct {
      logic [BYTE_W-1:0] out_byte;
      logic              is_status;
      logic [STAT_W-1:0] status;
      logic              last;
   } raw_word_type;

   logic clock = 1'b0;
   logic reset;

   edr_req_if req_ch ();
   edr_rsp_if rsp_ch ();

   ecdsa_der_to_raw_signature dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   der_word_type der_words_out [$];
   raw_word_type raw_words_due [$];
   int words_queued = 0;
   int words_taken = 0;
   int failures = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int holds_asked = 0;
   int quiet_cycles = 0;

   der_word_type directed_words [24] = '{
      '{8'h31, 1'b1, 1'b1, ST_SEQ_TAG},
      '{TAG_SEQUENCE, 1'b0, 1'b0, ST_OK},
      '{8'h83, 1'b0, 1'b1, ST_BAD_LEN},
      '{8'hFF, 1'b1, 1'b0, ST_OK},
      '{TAG_SEQUENCE, 1'b1, 1'b1, ST_TRUNC},
      '{TAG_SEQUENCE, 1'b0, 1'b0, ST_OK},
      '{8'h00, 1'b0, 1'b0, ST_OK},
      '{TAG_INTEGER, 1'b1, 1'b1, ST_MISMATCH},
      '{TAG_SEQUENCE, 1'b0, 1'b0, ST_OK},
      '{LEN_LONG1, 1'b0, 1'b0, ST_OK},
      '{8'h06, 1'b0, 1'b0, ST_OK},
      '{8'h03, 1'b0, 1'b1, ST_INT_TAG},
      '{8'h00, 1'b1, 1'b0, ST_OK},
      '{TAG_SEQUENCE, 1'b0, 1'b0, ST_OK},
      '{8'h06, 1'b0, 1'b0, ST_OK},
      '{TAG_INTEGER, 1'b0, 1'b0, ST_OK},
      '{8'h22, 1'b0, 1'b1, ST_TOO_LONG},
      '{8'h00, 1'b1, 1'b0, ST_OK},
      '{TAG_SEQUENCE, 1'b0, 1'b0, ST_OK},
      '{8'h04, 1'b0, 1'b0, ST_OK},
      '{TAG_INTEGER, 1'b0, 1'b0, ST_OK},
      '{8'h00, 1'b0, 1'b0, ST_OK},
      '{TAG_INTEGER, 1'b0, 1'b0, ST_OK},
      '{8'h00, 1'b1, 1'b0, ST_OK}
   };

   der_parse_type parse_at;
   logic [15:0]   seq_len;
   int            len_ext_left;
   int            seq_count;
   int            value_left;
   int            lead_drop;
   logic          on_s;

   task automatic add_raw(ref raw_word_type q [$], input raw_word_type w);
      q.insert(q.size(), w);
   endtask

   task automatic add_der(ref der_word_type q [$], input der_word_type w);
      q.insert(q.size(), w);
   endtask

   task automatic add_byte(ref logic [7:0] q [$], input logic [7:0] v);
      q.insert(q.size(), v);
   endtask

   function automatic raw_word_type data_word(input logic [7:0] v);
      return '{v, 1'b0, ST_OK, 1'b0};
   endfunction

   function automatic raw_word_type status_word(input logic [STAT_W-1:0] st);
      return '{8'h00, 1'b1, st, 1'b1};
   endfunction

   function automatic logic seq_len_known();
      return parse_at >= AT_INT_TAG && parse_at <= AT_TAIL;
   endfunction

   task automatic restart_parse();
      parse_at = AT_SEQ_TAG;
      seq_len = 16'h0000;
      len_ext_left = 0;
      seq_count = 0;
      value_left = 0;
      lead_drop = 0;
      on_s = 1'b0;
   endtask

   task automatic close_integer();
      if (!on_s) begin
         on_s = 1'b1;
         parse_at = AT_INT_TAG;
      end else begin
         parse_at = AT_TAIL;
      end
   endtask

   task automatic open_integer(input int n, ref raw_word_type res [$]);
      if (n < COORD_BYTES) begin
         repeat (COORD_BYTES - n) add_raw(res, data_word(8'h00));
         lead_drop = 0;
      end else begin
         lead_drop = n - COORD_BYTES;
      end
      value_left = n;
      if (n == 0) close_integer();
      else parse_at = AT_INT_VALUE;
   endtask

   task automatic decode_der_word(input der_word_type w, ref raw_word_type res [$]);
      logic [STAT_W-1:0] err;
      logic [7:0]        b;
      err = ST_OK;
      b = w.value;
      if (parse_at == AT_DISCARD) begin
         if (w.fin) restart_parse();
         return;
      end
      if (seq_len_known()) begin
         seq_count++;
         if (seq_count > seq_len || (w.fin && seq_count != seq_len)) err = ST_MISMATCH;
      end
      if (err == ST_OK) begin
         case (parse_at)
            AT_SEQ_TAG: begin
               if (b != TAG_SEQUENCE) err = ST_SEQ_TAG;
               else parse_at = AT_SEQ_LEN;
            end
            AT_SEQ_LEN: begin
               if (b < LEN_LONG_FORM) begin
                  seq_len = {8'h00, b};
                  parse_at = AT_INT_TAG;
               end else if (b == LEN_LONG1 || b == LEN_LONG2) begin
                  seq_len = 16'h0000;
                  len_ext_left = (b == LEN_LONG1) ? 1 : 2;
                  parse_at = AT_SEQ_LEN_EXT;
               end else begin
                  err = ST_BAD_LEN;
               end
            end
            AT_SEQ_LEN_EXT: begin
               seq_len = {seq_len[7:0], b};
               len_ext_left--;
               if (len_ext_left == 0) parse_at = AT_INT_TAG;
            end
            AT_INT_TAG: begin
               if (b != TAG_INTEGER) err = ST_INT_TAG;
               else parse_at = AT_INT_LEN;
            end
            AT_INT_LEN: begin
               if (b < LEN_LONG_FORM) begin
                  if (b > MAX_INT_BYTES) err = ST_TOO_LONG;
                  else open_integer(b, res);
               end else if (b == LEN_LONG1 || b == LEN_LONG2) begin
                  len_ext_left = (b == LEN_LONG1) ? 1 : 2;
                  parse_at = AT_INT_LEN_EXT;
               end else begin
                  err = ST_BAD_LEN;
               end
            end
            AT_INT_LEN_EXT: begin
               if (len_ext_left > 1) begin
                  if (b != 8'h00) err = ST_TOO_LONG;
                  else len_ext_left--;
               end else begin
                  len_ext_left = 0;
                  if (b > MAX_INT_BYTES) err = ST_TOO_LONG;
                  else open_integer(b, res);
               end
            end
            AT_INT_VALUE: begin
               if (lead_drop > 0) lead_drop--;
               else add_raw(res, data_word(b));
               value_left--;
               if (value_left == 0) close_integer();
            end
            default: ;
         endcase
      end
      if (err == ST_OK && w.fin) begin
         if (seq_len_known() && seq_count != seq_len) err = ST_MISMATCH;
         else if (parse_at != AT_TAIL) err = ST_TRUNC;
      end
      if (err != ST_OK) begin
         add_raw(res, status_word(err));
         if (w.fin) restart_parse();
         else parse_at = AT_DISCARD;
      end else if (w.fin) begin
         add_raw(res, status_word(ST_OK));
         restart_parse();
      end
   endtask

   task automatic queue_signature();
      logic [7:0]   sig [$];
      logic [7:0]   body [$];
      der_word_type w;
      int           pick;
      int           n;
      int           seq_total;
      int           cut;
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
         add_byte(sig, ($urandom_range(0, 3) == 0) ? TAG_SEQUENCE : 8'($urandom_range(0, 255)));
         repeat ($urandom_range(0, 5)) add_byte(sig, 8'($urandom_range(0, 255)));
      end else begin
         for (int k = 0; k < 2; k++) begin
            n = $urandom_range(0, 99);
            if (n < 70) n = $urandom_range(0, 4);
            else if (n < 85) n = $urandom_range(28, 33);
            else if (n < 95) n = $urandom_range(5, 27);
            else n = $urandom_range(34, 40);
            add_byte(body, TAG_INTEGER);
            case ($urandom_range(0, 3))
               2: begin
                  add_byte(body, LEN_LONG1);
                  add_byte(body, 8'(n));
               end
               3: begin
                  add_byte(body, LEN_LONG2);
                  add_byte(body, 8'h00);
                  add_byte(body, 8'(n));
               end
               default: add_byte(body, 8'(n));
            endcase
            repeat (n) add_byte(body, 8'($urandom_range(0, 255)));
         end
         if ($urandom_range(0, 9) < 3) begin
            repeat ($urandom_range(1, 3)) add_byte(body, 8'($urandom_range(0, 255)));
         end
         seq_total = body.size();
         if (pick < 14) seq_total = ($urandom_range(0, 1) == 0) ? seq_total - 1 : seq_total + 1;
         add_byte(sig, TAG_SEQUENCE);
         case ($urandom_range(0, 3))
            2: begin
               add_byte(sig, LEN_LONG1);
               add_byte(sig, 8'(seq_total));
            end
            3: begin
               add_byte(sig, LEN_LONG2);
               add_byte(sig, 8'(seq_total >> 8));
               add_byte(sig, 8'(seq_total));
            end
            default: add_byte(sig, 8'(seq_total));
         endcase
         foreach (body[i]) add_byte(sig, body[i]);
         if (pick >= 14 && pick < 30) begin
            case ($urandom_range(0, 2))
               0: sig[$urandom_range(0, sig.size() - 1)] = 8'($urandom_range(0, 255));
               1: begin
                  cut = $urandom_range(1, sig.size() - 1);
                  while (sig.size() > cut) void'(sig.pop_back());
               end
               default: repeat ($urandom_range(1, 3)) add_byte(sig, 8'($urandom_range(0, 255)));
            endcase
         end
      end
      foreach (sig[i]) begin
         w.value = sig[i];
         w.fin = (i == sig.size() - 1);
         w.pinned = 1'b0;
         w.pinned_status = ST_OK;
         add_der(der_words_out, w);
         words_queued++;
      end
   endtask

   task automatic wait_drained();
      while (words_taken != words_queued || raw_words_due.size() != 0) @(posedge clock);
   endtask

   task automatic compare_field(input string name, input logic [7:0] want,
                                input logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         failures++;
      end
   endtask

   initial begin : drive_der
      der_word_type offered;
      raw_word_type produced [$];
      req_ch.valid <= 1'b0;
      req_ch.der_byte <= 8'h00;
      req_ch.final_byte <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset) begin
            if (req_ch.valid && req_ch.ready) begin
               produced.delete();
               decode_der_word(offered, produced);
               if (offered.pinned) add_raw(raw_words_due, status_word(offered.pinned_status));
               else foreach (produced[i]) add_raw(raw_words_due, produced[i]);
               words_taken++;
            end
            if (!req_ch.valid || req_ch.ready) begin
               if (der_words_out.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                  offered = der_words_out.pop_front();
                  req_ch.valid <= 1'b1;
                  req_ch.der_byte <= offered.value;
                  req_ch.final_byte <= offered.fin;
               end else begin
                  req_ch.valid <= 1'b0;
               end
            end
         end
      end
   end

   initial begin : drive_raw_ready
      int hold_left;
      int holds_done;
      hold_left = 0;
      holds_done = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (holds_done != holds_asked) begin
            holds_done++;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
         end
      end
   end

   always @(posedge clock) begin : check_raw
      raw_word_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (raw_words_due.size() == 0) begin
            $error("raw word with nothing expected: out_byte %0h is_status %0b status %0d",
                   rsp_ch.out_byte, rsp_ch.is_status, rsp_ch.status);
            failures++;
         end else begin
            want = raw_words_due.pop_front();
            compare_field("out_byte", want.out_byte, rsp_ch.out_byte);
            compare_field("is_status", want.is_status, rsp_ch.is_status);
            compare_field("status", want.status, rsp_ch.status);
            compare_field("last", want.last, rsp_ch.last);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
   end

   initial begin : watchdog
      do @(posedge clock); while (quiet_cycles < WATCHDOG_LIMIT);
      $display("FAIL");
      $finish;
   end

   initial begin : run
      int phase_start;
      restart_parse();
      reset <= 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      foreach (directed_words[i]) begin
         add_der(der_words_out, directed_words[i]);
         words_queued++;
      end
      wait_drained();
      for (int p = 0; p < 4; p++) begin
         case (p)
            0: begin
               send_idle_pct = 0;
               recv_stall_pct = 0;
            end
            1: begin
               send_idle_pct = 66;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               recv_stall_pct = 66;
            end
            default: begin
               send_idle_pct = 26;
               recv_stall_pct = 26;
            end
         endcase
         phase_start = words_queued;
         while (words_queued - phase_start < PHASE_WORDS) queue_signature();
         // hold the output off while the input keeps offering
         if (p == 0) holds_asked++;
         wait_drained();
      end
      repeat (TAIL_CYCLES) @(posedge clock);
      if (failures == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

endmodule
